@@ rtl/sobel_heightmap_normal_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the height-map normal block
// Concurrent checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SOBEL_HEIGHTMAP_NORMAL_MACROS_SVH
`define SOBEL_HEIGHTMAP_NORMAL_MACROS_SVH
`ifndef SYNTHESIS
`define SHN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shn assertion failed");
`define SHN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shn assertion failed");
`else
`define SHN_ASSERT_IMP(lbl, ante, cons)
`define SHN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/shn_pkg.sv @@
// ---------------------------------------------------------------------------
// shn_pkg
// Shared constants and types for the height-map normal block.
// ---------------------------------------------------------------------------
package shn_pkg;
  localparam int MAX_SIDE    = 1024;
  localparam int HEIGHT_BITS = 15;
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int SIZE_W      = 11;
  localparam int GAIN_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_W       = 16;
  localparam int GRAD_W      = HEIGHT_BITS + 4;
  localparam int MAG_W       = GRAD_W - 1;
  localparam int PROD_W      = MAG_W + GAIN_W;
  localparam int NORM_W      = 30;
  localparam int ROOT_W      = NORM_W + 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEGACY_UP   = 3'd4;

  localparam logic [3:0] UP_STD    = 4'd8;
  localparam logic [3:0] UP_LEGACY = 4'd5;

  typedef logic [COORD_W-1:0]     coord_t;
  typedef logic [HEIGHT_BITS-1:0] height_t;
  typedef logic [OUT_W-1:0]       comp_t;
endpackage

@@ rtl/shn_if.sv @@
// ---------------------------------------------------------------------------
// Channel interfaces
// Request, result and configuration channels with valid/ready.
// ---------------------------------------------------------------------------
interface shn_req_if;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  shn_pkg::coord_t         pos_x;
  shn_pkg::coord_t         pos_y;
  shn_pkg::height_t        height_sample;
  modport source(output valid, cmd, pos_x, pos_y, height_sample, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, height_sample, output ready);
endinterface

interface shn_rsp_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   normal_x;
  logic signed [15:0]   normal_up;
  logic signed [15:0]   normal_z;
  modport source(output valid, normal_x, normal_up, normal_z, input ready);
  modport sink(input valid, normal_x, normal_up, normal_z, output ready);
endinterface

interface shn_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [shn_pkg::CFG_IDX_W-1:0]       addr;
  logic [shn_pkg::CFG_DATA_W-1:0]      data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

@@ rtl/sobel_heightmap_normal.sv @@
// A write goes into the height memory when it is accepted. A query holds the sequencer from
// acceptance to its result word: eight reads on the single height memory read port, two gain
// products and three squares on one shared 32x32 multiplier, a 0 to 19 step range shift,
// a 32-step square root and three 16-step restoring divisions. One item is in flight, so
// a query also holds it through any stall on an unread result. After reset the
// height memory is swept to zero, during which no request is accepted.
// ---------------------------------------------------------------------------
// sobel_heightmap_normal
// Height store with Sobel gradient and normalised surface normal query.
// ---------------------------------------------------------------------------
`include "sobel_heightmap_normal_macros.svh"

module sobel_heightmap_normal (
  input  logic       clk,
  input  logic       rst,
  shn_req_if.sink    req,
  shn_rsp_if.source  rsp,
  shn_cfg_if.sink    cfg
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_LAST  = 4'd3;
  localparam logic [3:0] S_MULA  = 4'd4;
  localparam logic [3:0] S_MULC  = 4'd5;
  localparam logic [3:0] S_NORM  = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DIVI  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam int AW = shn_pkg::ADDR_W;
  localparam int CW = shn_pkg::COORD_W;
  localparam int GW = shn_pkg::GRAD_W;
  localparam int MW = shn_pkg::MAG_W;
  localparam int PW = shn_pkg::PROD_W;
  localparam int NW = shn_pkg::NORM_W;
  localparam int RW = shn_pkg::ROOT_W;
  localparam int HB = shn_pkg::HEIGHT_BITS;

  // configuration
  logic [shn_pkg::SIZE_W-1:0] grid_width, grid_height;
  logic [shn_pkg::GAIN_W-1:0] x_gain, z_gain;
  logic                       legacy_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= shn_pkg::SIZE_W'(33);
      grid_height <= shn_pkg::SIZE_W'(33);
      x_gain      <= shn_pkg::GAIN_W'(512);
      z_gain      <= shn_pkg::GAIN_W'(512);
      legacy_up   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        shn_pkg::REG_GRID_WIDTH:  grid_width  <= cfg.data[shn_pkg::SIZE_W-1:0];
        shn_pkg::REG_GRID_HEIGHT: grid_height <= cfg.data[shn_pkg::SIZE_W-1:0];
        shn_pkg::REG_X_GAIN:      x_gain      <= cfg.data;
        shn_pkg::REG_Z_GAIN:      z_gain      <= cfg.data;
        shn_pkg::REG_LEGACY_UP:   legacy_up   <= cfg.data[0];
        default: ;
      endcase
    end
  end
  assign cfg.ready = 1'b1;

  shn_pkg::coord_t wmax, hmax;
  assign wmax = (grid_width == '0) ? '0 :
                (grid_width > shn_pkg::SIZE_W'(shn_pkg::MAX_SIDE)) ?
                CW'(shn_pkg::MAX_SIDE - 1) : CW'(grid_width - 1'b1);
  assign hmax = (grid_height == '0) ? '0 :
                (grid_height > shn_pkg::SIZE_W'(shn_pkg::MAX_SIDE)) ?
                CW'(shn_pkg::MAX_SIDE - 1) : CW'(grid_height - 1'b1);

  // sequencer state
  logic [3:0]          state;
  logic                clr;
  logic [AW-1:0]       clr_cnt;
  logic [4:0]          cnt;
  logic [1:0]          comp;
  shn_pkg::coord_t     px, py, cx, cy;
  logic                acc_v;
  logic [2:0]          acc_k;
  logic signed [GW-1:0] gx, gz;
  logic [PW-1:0]       ma, mb, mc;
  logic [63:0]         sum, sv, sres, sbit;
  logic [RW-1:0]       r;
  logic [RW-1:0]       rem;
  logic [15:0]         nlo, q;
  shn_pkg::comp_t      nx, nu, nz;
  logic                out_valid;
  shn_pkg::comp_t      ox, ou, oz;

  logic accept;
  assign req.ready = (state == S_IDLE) && !clr;
  assign accept    = req.valid && req.ready;

  // neighbour addressing
  shn_pkg::coord_t xl, xr, yl, yr, rx, ry;
  assign xl = (cx == '0) ? cx : cx - 1'b1;
  assign xr = (cx == wmax) ? cx : cx + 1'b1;
  assign yl = (cy == '0) ? cy : cy - 1'b1;
  assign yr = (cy == hmax) ? cy : cy + 1'b1;

  always_comb begin
    unique case (cnt[2:0])
      3'd0, 3'd1, 3'd2: rx = xl;
      3'd3, 3'd4:       rx = cx;
      default:          rx = xr;
    endcase
    unique case (cnt[2:0])
      3'd0, 3'd3, 3'd5: ry = yl;
      3'd1, 3'd6:       ry = cy;
      default:          ry = yr;
    endcase
  end

  // height memory
  logic [HB-1:0] mem [shn_pkg::MAX_SIDE * shn_pkg::MAX_SIDE];
  logic [HB-1:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [HB-1:0] mem_wdata;

  assign mem_we    = clr || (accept && req.cmd == shn_pkg::CMD_WRITE);
  assign mem_waddr = clr ? clr_cnt : {req.pos_x, req.pos_y};
  assign mem_wdata = clr ? '0 : req.height_sample;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end
  always_ff @(posedge clk) begin
    rdata <= mem[{rx, ry}];
  end

  // shared multiplier
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;
  logic [MW-1:0] agx, agz;
  logic [NW-1:0] sq_op;
  assign agx = gx[GW-1] ? MW'(-gx) : MW'(gx);
  assign agz = gz[GW-1] ? MW'(-gz) : MW'(gz);

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    sq_op = ma[NW-1:0];
      2'd1:    sq_op = mb[NW-1:0];
      default: sq_op = mc[NW-1:0];
    endcase
    priority case (state)
      S_MULA: begin
        mul_x = 32'(agx);
        mul_y = x_gain;
      end
      S_MULC: begin
        mul_x = 32'(agz);
        mul_y = z_gain;
      end
      default: begin
        mul_x = 32'(sq_op);
        mul_y = 32'(sq_op);
      end
    endcase
  end
  assign prod = 64'(mul_x) * 64'(mul_y);

  // square root step
  logic [63:0] s_try;
  assign s_try = sres + sbit;

  // division step
  logic [NW-1:0]  dm;
  logic [NW+15:0] num;
  logic [RW:0]    dt;
  logic           qbit;
  logic [15:0]    qf;
  logic           neg;
  shn_pkg::comp_t enc;

  always_comb begin
    unique case (comp)
      2'd0:    dm = ma[NW-1:0];
      2'd1:    dm = mb[NW-1:0];
      default: dm = mc[NW-1:0];
    endcase
  end
  assign num  = {1'b0, dm, 15'b0} + (NW + 16)'(r >> 1);
  assign dt   = {rem, nlo[15]};
  assign qbit = dt >= {1'b0, r};
  assign qf   = {q[14:0], qbit};
  assign neg  = (comp == 2'd0) ? (gx > 0) : (comp == 2'd2) ? (gz > 0) : 1'b0;
  assign enc  = neg ? ((qf > 16'd32768) ? 16'h8000 : (~qf + 16'd1)) :
                ((qf > 16'd32767) ? 16'h7FFF : qf);

  logic signed [GW-1:0] h, h2;
  assign h  = GW'(signed'({1'b0, rdata}));
  assign h2 = h <<< 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clr       <= 1'b1;
      clr_cnt   <= '0;
      cnt       <= '0;
      comp      <= '0;
      acc_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clr) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (&clr_cnt) begin
          clr <= 1'b0;
        end
      end
      if (out_valid && rsp.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      acc_v <= (state == S_READ);
      acc_k <= cnt[2:0];
      if (acc_v) begin
        unique case (acc_k)
          3'd0: begin gx <= gx - h;  gz <= gz - h;  end
          3'd1: begin gx <= gx - h2;                end
          3'd2: begin gx <= gx - h;  gz <= gz + h;  end
          3'd3: begin                gz <= gz - h2; end
          3'd4: begin                gz <= gz + h2; end
          3'd5: begin gx <= gx + h;  gz <= gz - h;  end
          3'd6: begin gx <= gx + h2;                end
          default: begin gx <= gx + h; gz <= gz + h; end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req.cmd == shn_pkg::CMD_QUERY) begin
            px    <= req.pos_x;
            py    <= req.pos_y;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          cx    <= (px > wmax) ? wmax : px;
          cy    <= (py > hmax) ? hmax : py;
          gx    <= '0;
          gz    <= '0;
          cnt   <= '0;
          state <= S_READ;
        end
        S_READ: begin
          cnt <= cnt + 1'b1;
          if (cnt[2:0] == 3'd7) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_MULA;
        end
        S_MULA: begin
          ma    <= prod[PW-1:0];
          mb    <= PW'({legacy_up ? shn_pkg::UP_LEGACY : shn_pkg::UP_STD, 24'b0});
          state <= S_MULC;
        end
        S_MULC: begin
          mc    <= prod[PW-1:0];
          state <= S_NORM;
        end
        S_NORM: begin
          if (|{ma[PW-1:NW], mb[PW-1:NW], mc[PW-1:NW]}) begin
            ma <= ma >> 1;
            mb <= mb >> 1;
            mc <= mc >> 1;
          end else begin
            cnt   <= '0;
            sum   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sum <= sum + prod;
          if (cnt[1:0] == 2'd2) begin
            sv    <= sum + prod;
            sres  <= '0;
            sbit  <= 64'd1 << 62;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          if (sv >= s_try) begin
            sv   <= sv - s_try;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            comp  <= '0;
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          q <= '0;
          if (cnt == 5'd0 && comp == 2'd0) begin
            r   <= (sres == '0) ? RW'(1) : sres[RW-1:0];
            cnt <= 5'd1;
          end else begin
            rem   <= RW'(num[NW+15:16]);
            nlo   <= num[15:0];
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= qbit ? RW'(dt - {1'b0, r}) : dt[RW-1:0];
          nlo <= nlo << 1;
          q   <= qf;
          if (cnt == 5'd15) begin
            unique case (comp)
              2'd0:    nx <= enc;
              2'd1:    nu <= enc;
              default: nz <= enc;
            endcase
            comp <= comp + 1'b1;
            cnt  <= 5'd1;
            state <= (comp == 2'd2) ? S_OUT : S_DIVI;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            ox        <= nx;
            ou        <= nu;
            oz        <= nz;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.normal_x  = ox;
  assign rsp.normal_up = ou;
  assign rsp.normal_z  = oz;

  `SHN_ASSERT_IMP(a_no_query_in_clear, state != S_IDLE, !clr)
  `SHN_ASSERT_IMP(a_grad_range, state == S_MULA,
                  gx <= GW'(131068) && gx >= -GW'(131068) &&
                  gz <= GW'(131068) && gz >= -GW'(131068))
  `SHN_ASSERT_IMP(a_rem_below_divisor, state == S_DIV, rem < r)
  `SHN_ASSERT_NXT(a_result_from_out, state == S_OUT && (!out_valid || rsp.ready),
                  out_valid && state == S_IDLE)

endmodule

@@ sim/sobel_heightmap_normal_test.sv @@
// ---------------------------------------------------------------------------
// sobel_heightmap_normal_test
// Self-checking bench for the height-map normal block: writes and queries
// go in on the request channel, every normal word that comes back is checked
// against a behavioural prediction, across several register settings.
// ---------------------------------------------------------------------------
module sobel_heightmap_normal_test;

  localparam longint CYCLE_LIMIT = 8000000;
  localparam int     SETTLE      = 200;
  localparam int     NWORD_W     = 3 * shn_pkg::OUT_W;

  class heightmap_normal_predictor;
    shn_pkg::height_t heights[int];
    logic [shn_pkg::SIZE_W-1:0] grid_w, grid_h;
    logic [shn_pkg::GAIN_W-1:0] gain_x, gain_z;
    logic              legacy;
    logic [NWORD_W-1:0] expected_normals[$];
    int errors;

    function void clear();
      heights.delete();
      grid_w = 11'd33; grid_h = 11'd33; gain_x = 32'd512; gain_z = 32'd512; legacy = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [shn_pkg::CFG_IDX_W-1:0] idx,
                          logic [shn_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        shn_pkg::REG_GRID_WIDTH: begin
          grid_w = val[shn_pkg::SIZE_W-1:0];
        end
        shn_pkg::REG_GRID_HEIGHT: begin
          grid_h = val[shn_pkg::SIZE_W-1:0];
        end
        shn_pkg::REG_X_GAIN: begin
          gain_x = val;
        end
        shn_pkg::REG_Z_GAIN: begin
          gain_z = val;
        end
        shn_pkg::REG_LEGACY_UP: begin
          legacy = val[0];
        end
        default: ;
      endcase
    endfunction

    function int lim(int v, int hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function longint height_at(int x, int y, int xm, int ym);
      int key;
      key = lim(x, xm) * shn_pkg::MAX_SIDE + lim(y, ym);
      return heights.exists(key) ? longint'(heights[key]) : 0;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function shn_pkg::comp_t to_q15(longint unsigned m, longint unsigned r, bit neg);
      longint unsigned q;
      q = (m * 32768 + r / 2) / r;
      if (neg) begin
        if (q > 32768) q = 32768;
        return shn_pkg::comp_t'(17'h10000 - q);
      end
      if (q > 32767) q = 32767;
      return shn_pkg::comp_t'(q);
    endfunction

    function void log_request(logic cmd, shn_pkg::coord_t px, shn_pkg::coord_t py,
                              shn_pkg::height_t hs);
      int xm, ym, x, y, s;
      longint h00, h01, h02, h10, h12, h20, h21, h22, gx, gz;
      longint unsigned a, b, c, mx, r;
      logic [NWORD_W-1:0] entry;
      if (cmd == shn_pkg::CMD_WRITE) begin
        heights[int'(px) * shn_pkg::MAX_SIDE + int'(py)] = hs;
        return;
      end
      xm = (grid_w < 1 ? 1 : (grid_w > shn_pkg::MAX_SIDE ? shn_pkg::MAX_SIDE
                                                          : int'(grid_w))) - 1;
      ym = (grid_h < 1 ? 1 : (grid_h > shn_pkg::MAX_SIDE ? shn_pkg::MAX_SIDE
                                                          : int'(grid_h))) - 1;
      x = lim(int'(px), xm);
      y = lim(int'(py), ym);
      h00 = height_at(x-1, y-1, xm, ym); h01 = height_at(x-1, y, xm, ym);
      h02 = height_at(x-1, y+1, xm, ym); h10 = height_at(x, y-1, xm, ym);
      h12 = height_at(x, y+1, xm, ym);   h20 = height_at(x+1, y-1, xm, ym);
      h21 = height_at(x+1, y, xm, ym);   h22 = height_at(x+1, y+1, xm, ym);
      gx = (h20 + 2*h21 + h22) - (h00 + 2*h01 + h02);
      gz = (h02 + 2*h12 + h22) - (h00 + 2*h10 + h20);
      a = longint'(gx < 0 ? -gx : gx) * longint'({32'd0, gain_x});
      c = longint'(gz < 0 ? -gz : gz) * longint'({32'd0, gain_z});
      b = longint'(legacy ? shn_pkg::UP_LEGACY : shn_pkg::UP_STD) << 24;
      mx = a;
      if (b > mx) mx = b;
      if (c > mx) mx = c;
      s = 0;
      while ((mx >> s) >= (64'd1 << 30)) s++;
      a >>= s; b >>= s; c >>= s;
      r = root(a*a + b*b + c*c);
      if (r == 0) r = 1;
      entry = {to_q15(a, r, gx > 0), to_q15(b, r, 1'b0), to_q15(c, r, gz > 0)};
      expected_normals = {expected_normals, entry};
    endfunction

    function void check_normal(shn_pkg::comp_t nx, shn_pkg::comp_t nu, shn_pkg::comp_t nz);
      logic [NWORD_W-1:0] e;
      if (expected_normals.size() == 0) begin
        $error("normal word with none expected: %0d %0d %0d",
               $signed(nx), $signed(nu), $signed(nz));
        errors++;
        return;
      end
      e = expected_normals.pop_front();
      if (nx !== e[47:32]) begin
        $error("normal_x expected %0d actual %0d", $signed(e[47:32]), $signed(nx));
        errors++;
      end
      if (nu !== e[31:16]) begin
        $error("normal_up expected %0d actual %0d", $signed(e[31:16]), $signed(nu));
        errors++;
      end
      if (nz !== e[15:0]) begin
        $error("normal_z expected %0d actual %0d", $signed(e[15:0]), $signed(nz));
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  shn_req_if req();
  shn_rsp_if rsp();
  shn_cfg_if cfg();

  sobel_heightmap_normal DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  heightmap_normal_predictor normals = new();
  longint cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  always #5 clk = ~clk;

  initial begin
    req.valid = 0; req.cmd = 0; req.pos_x = 0; req.pos_y = 0; req.height_sample = 0;
    cfg.valid = 0; cfg.addr = 0; cfg.data = 0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: stall pattern switches between always ready, light and heavy
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      normals.check_normal(rsp.normal_x, rsp.normal_up, rsp.normal_z);
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      default: rsp.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_word(logic cmd, shn_pkg::coord_t px, shn_pkg::coord_t py,
                           shn_pkg::height_t hs);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.cmd <= cmd; req.pos_x <= px; req.pos_y <= py; req.height_sample <= hs;
    do @(posedge clk); while (!req.ready);
    normals.log_request(cmd, px, py, hs);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    while (normals.expected_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [shn_pkg::CFG_IDX_W-1:0] idx,
                           logic [shn_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1; cfg.addr <= idx; cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    normals.set_reg(idx, val);
  endtask

  task automatic set_all(int gw, int gh, logic [31:0] gxv, logic [31:0] gzv, bit lg);
    write_reg(shn_pkg::REG_GRID_WIDTH, 32'(gw));
    write_reg(shn_pkg::REG_GRID_HEIGHT, 32'(gh));
    write_reg(shn_pkg::REG_X_GAIN, gxv);
    write_reg(shn_pkg::REG_Z_GAIN, gzv);
    write_reg(shn_pkg::REG_LEGACY_UP, 32'(lg));
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(0, 4096);
      default: return $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1);
      1: return 1024;
      2: return $urandom_range(1025, 2047);
      3: return $urandom_range(2, 1024);
      default: return $urandom_range(2, 10);
    endcase
  endfunction

  task automatic random_phase(int count);
    int gw, gh, ew, eh, side_w, side_h, bx, by;
    gw = pick_size(); gh = pick_size();
    set_all(gw, gh, pick_gain(), pick_gain(), 1'($urandom_range(0, 1)));
    ew = gw < 1 ? 1 : (gw > shn_pkg::MAX_SIDE ? shn_pkg::MAX_SIDE : gw);
    eh = gh < 1 ? 1 : (gh > shn_pkg::MAX_SIDE ? shn_pkg::MAX_SIDE : gh);
    side_w = ew < 12 ? ew : 12;
    side_h = eh < 12 ? eh : 12;
    bx = $urandom_range(0, ew - side_w);
    by = $urandom_range(0, eh - side_h);
    repeat (count) begin
      shn_pkg::coord_t px, py;
      shn_pkg::height_t hs;
      if ($urandom_range(0, 9) == 0) begin
        px = shn_pkg::coord_t'($urandom_range(0, 1023));
        py = shn_pkg::coord_t'($urandom_range(0, 1023));
      end else begin
        px = shn_pkg::coord_t'(bx + $urandom_range(0, side_w + 1));
        py = shn_pkg::coord_t'(by + $urandom_range(0, side_h + 1));
      end
      case ($urandom_range(0, 3))
        0: hs = 15'h7FFF;
        1: hs = '0;
        default: hs = shn_pkg::height_t'($urandom);
      endcase
      send_word($urandom_range(0, 1) ? shn_pkg::CMD_QUERY : shn_pkg::CMD_WRITE,
                px, py, hs);
    end
    drain();
  endtask

  initial begin
    normals.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // reset settings: corners, a clamped query, extreme heights
    send_word(shn_pkg::CMD_QUERY, 10'd0, 10'd0, 15'd0);
    send_word(shn_pkg::CMD_WRITE, 10'd0, 10'd0, 15'h7FFF);
    send_word(shn_pkg::CMD_WRITE, 10'd1023, 10'd1023, 15'd32766);
    send_word(shn_pkg::CMD_WRITE, 10'd1, 10'd0, 15'd32766);
    send_word(shn_pkg::CMD_WRITE, 10'd32, 10'd32, 15'h7FFF);
    send_word(shn_pkg::CMD_QUERY, 10'd0, 10'd0, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd1, 10'd1, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd1023, 10'd1023, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd31, 10'd31, 15'd0);
    drain();
    set_all(1024, 1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(shn_pkg::CMD_WRITE, 10'd1022, 10'd1023, 15'h7FFF);
    send_word(shn_pkg::CMD_QUERY, 10'd1023, 10'd1023, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd1022, 10'd1022, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd0, 10'd1, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd500, 10'd500, 15'd0);
    drain();
    set_all(0, 2047, 32'd0, 32'h0100_0000, 1'b0);
    send_word(shn_pkg::CMD_QUERY, 10'd1023, 10'd0, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd0, 10'd1023, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd5, 10'd1, 15'd0);
    drain();
    set_all(2, 1, 32'h0000_1000, 32'd0, 1'b1);
    send_word(shn_pkg::CMD_QUERY, 10'd1, 10'd0, 15'd0);
    send_word(shn_pkg::CMD_QUERY, 10'd0, 10'd0, 15'd0);
    drain();
    repeat (10) random_phase(155);
    if (normals.errors == 0 && normals.expected_normals.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/shn_pkg.sv
rtl/shn_if.sv
rtl/sobel_heightmap_normal.sv
sim/sobel_heightmap_normal_test.sv
